[rtl/exl_pkg.sv]
// ----------------------------------------------------------------------------
// exl_pkg: shared types and constants of the expression lexer
// Beat types of both channels, lexer modes, token kinds, the operator
// characters and the operator-kind decode.
// ----------------------------------------------------------------------------
package exl_pkg;

	typedef struct packed {
		logic [7:0] char_in;
		logic       final_char;
	} char_beat_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [31:0] number_value;
		logic        number_overflow;
		logic [7:0]  first_char;
		logic [7:0]  second_char;
		logic        last_of_run;
	} token_t;

	typedef enum logic [1:0] {
		MODE_DEFAULT = 2'd0,
		MODE_OPER    = 2'd1,
		MODE_NUMBER  = 2'd2
	} lex_mode_t;

	// Lexer state apart from the number accumulator, whose width is a parameter.
	typedef struct packed {
		lex_mode_t  mode;
		logic [7:0] op_first;
		logic [7:0] op_second;
		logic [4:0] op_kind;
		logic       sat;
	} lex_state_t;

	localparam logic [4:0] KIND_UNKNOWN = 5'd0;
	localparam logic [4:0] KIND_ADD     = 5'd1;
	localparam logic [4:0] KIND_SUB     = 5'd2;
	localparam logic [4:0] KIND_MUL     = 5'd3;
	localparam logic [4:0] KIND_DIV     = 5'd4;
	localparam logic [4:0] KIND_LT      = 5'd5;
	localparam logic [4:0] KIND_LE      = 5'd6;
	localparam logic [4:0] KIND_GT      = 5'd7;
	localparam logic [4:0] KIND_GE      = 5'd8;
	localparam logic [4:0] KIND_ASSIGN  = 5'd9;
	localparam logic [4:0] KIND_EQ      = 5'd10;
	localparam logic [4:0] KIND_NOT     = 5'd11;
	localparam logic [4:0] KIND_NE      = 5'd12;
	localparam logic [4:0] KIND_OR      = 5'd13;
	localparam logic [4:0] KIND_AND     = 5'd14;
	localparam logic [4:0] KIND_LPAREN  = 5'd15;
	localparam logic [4:0] KIND_RPAREN  = 5'd16;
	localparam logic [4:0] KIND_NUMBER  = 5'd17;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	function automatic logic [4:0] oper_kind(input logic [7:0] first, input logic [7:0] second);
		logic eq;
		eq = (second == CH_EQUAL);
		case (first)
			CH_PLUS:  oper_kind = KIND_ADD;
			CH_MINUS: oper_kind = KIND_SUB;
			CH_STAR:  oper_kind = KIND_MUL;
			CH_SLASH: oper_kind = KIND_DIV;
			CH_LT:    oper_kind = eq ? KIND_LE : KIND_LT;
			CH_GT:    oper_kind = eq ? KIND_GE : KIND_GT;
			CH_EQUAL: oper_kind = eq ? KIND_EQ : KIND_ASSIGN;
			CH_BANG:  oper_kind = eq ? KIND_NE : KIND_NOT;
			CH_PIPE:  oper_kind = KIND_OR;
			CH_AMP:   oper_kind = KIND_AND;
			default:  oper_kind = KIND_UNKNOWN;
		endcase
	endfunction

endpackage

[rtl/exl_step.sv]
// ----------------------------------------------------------------------------
// exl_step: next-state and token logic of the expression lexer
// Takes one registered character and the lexer state, returns the next state
// and up to two tokens in order.
// ----------------------------------------------------------------------------
module exl_step #(
	parameter int NUMBER_WIDTH = 32
) (
	input  exl_pkg::char_beat_t      beat,
	input  exl_pkg::lex_state_t      st,
	input  logic [NUMBER_WIDTH-1:0]  acc,
	output exl_pkg::lex_state_t      st_nxt,
	output logic [NUMBER_WIDTH-1:0]  acc_nxt,
	output exl_pkg::token_t          tok0,
	output exl_pkg::token_t          tok1,
	output logic [1:0]               tok_count
);
	import exl_pkg::*;

	localparam int VW = (NUMBER_WIDTH > 32) ? NUMBER_WIDTH : 32;
	localparam int PW = NUMBER_WIDTH + 4;

	function automatic logic is_oper(input logic [7:0] c);
		is_oper = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
			(c == CH_SLASH) || (c == CH_LT) || (c == CH_GT) || (c == CH_EQUAL) ||
			(c == CH_BANG) || (c == CH_PIPE) || (c == CH_AMP);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	always_comb begin
		logic [7:0]    c;
		logic          do_dflt;
		logic          emit_pend;
		logic          paren_hit;
		logic          fin_hit;
		token_t        pend;
		token_t        paren;
		token_t        fin_tok;
		logic [PW-1:0] grown;
		logic [VW-1:0] acc_ext;
		logic [VW-1:0] nacc_ext;

		c         = beat.char_in;
		st_nxt    = st;
		acc_nxt   = acc;
		do_dflt   = 1'b0;
		emit_pend = 1'b0;
		paren_hit = 1'b0;
		paren     = '0;

		// acc * 10 + digit, four guard bits catch the overflow.
		grown   = (PW'(acc) << 3) + (PW'(acc) << 1) + PW'(c[3:0]);
		acc_ext = VW'(acc);

		// Token for whatever is pending before this character.
		pend = '0;
		if (st.mode == MODE_OPER) begin
			pend.token_kind  = st.op_kind;
			pend.first_char  = st.op_first;
			pend.second_char = st.op_second;
		end else begin
			pend.token_kind      = KIND_NUMBER;
			pend.number_value    = acc_ext[31:0];
			pend.number_overflow = st.sat;
		end

		unique case (st.mode)
			MODE_OPER: begin
				if (is_oper(c)) begin
					st_nxt.op_second = c;
					st_nxt.op_kind   = oper_kind(st.op_first, c);
				end else begin
					emit_pend = 1'b1;
					do_dflt   = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (is_digit(c)) begin
					if (st.sat || (grown[PW-1:NUMBER_WIDTH] != '0)) begin
						acc_nxt    = '1;
						st_nxt.sat = 1'b1;
					end else begin
						acc_nxt = grown[NUMBER_WIDTH-1:0];
					end
				end else begin
					emit_pend = 1'b1;
					do_dflt   = 1'b1;
				end
			end
			default: begin
				do_dflt = 1'b1;
			end
		endcase

		// The character that ended a token is handled again from default mode.
		if (do_dflt) begin
			st_nxt.mode = MODE_DEFAULT;
			if (is_oper(c)) begin
				st_nxt.op_first  = c;
				st_nxt.op_second = '0;
				st_nxt.op_kind   = oper_kind(c, '0);
				st_nxt.mode      = MODE_OPER;
			end else if (is_digit(c)) begin
				acc_nxt     = NUMBER_WIDTH'(c[3:0]);
				st_nxt.sat  = 1'b0;
				st_nxt.mode = MODE_NUMBER;
			end else if (c == CH_LPAREN) begin
				paren_hit        = 1'b1;
				paren.token_kind = KIND_LPAREN;
				paren.first_char = c;
			end else if (c == CH_RPAREN) begin
				paren_hit        = 1'b1;
				paren.token_kind = KIND_RPAREN;
				paren.first_char = c;
			end
		end

		// On the final character the token left pending is flushed.
		nacc_ext = VW'(acc_nxt);
		fin_tok  = '0;
		if (st_nxt.mode == MODE_OPER) begin
			fin_tok.token_kind  = st_nxt.op_kind;
			fin_tok.first_char  = st_nxt.op_first;
			fin_tok.second_char = st_nxt.op_second;
		end else begin
			fin_tok.token_kind      = KIND_NUMBER;
			fin_tok.number_value    = nacc_ext[31:0];
			fin_tok.number_overflow = st_nxt.sat;
		end
		fin_hit = beat.final_char && (st_nxt.mode != MODE_DEFAULT);
		if (beat.final_char) begin
			st_nxt.mode = MODE_DEFAULT;
		end

		tok0      = '0;
		tok1      = '0;
		tok_count = 2'd0;
		if (emit_pend) begin
			tok0      = pend;
			tok_count = 2'd1;
		end
		if (paren_hit) begin
			if (tok_count == 2'd0) begin
				tok0 = paren;
			end else begin
				tok1 = paren;
			end
			tok_count = tok_count + 2'd1;
		end
		if (fin_hit) begin
			if (tok_count == 2'd0) begin
				tok0 = fin_tok;
			end else begin
				tok1 = fin_tok;
			end
			tok_count = tok_count + 2'd1;
		end
		if (tok_count == 2'd1) begin
			tok0.last_of_run = 1'b1;
		end
		if (tok_count == 2'd2) begin
			tok1.last_of_run = 1'b1;
		end
	end

endmodule

[rtl/exl_queue.sv]
// ----------------------------------------------------------------------------
// exl_queue: four-entry token queue in front of the output channel
// Takes up to two tokens a cycle, hands out one token a cycle while tok_ready is high.
// ----------------------------------------------------------------------------
module exl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  exl_pkg::token_t push_tok0,
	input  exl_pkg::token_t push_tok1,
	input  logic [1:0]      push_count,
	output logic            room,
	output logic [2:0]      fill,
	output logic            tok_valid,
	input  logic            tok_ready,
	output exl_pkg::token_t tok_beat
);
	import exl_pkg::*;

	token_t     entry_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] fill_q;
	logic       pop;

	assign pop       = tok_valid && tok_ready;
	assign tok_valid = (fill_q != 3'd0);
	assign tok_beat  = entry_q[rd_ptr_q];
	assign room      = (fill_q <= 3'd2);
	assign fill      = fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_count;
			rd_ptr_q <= rd_ptr_q + 2'(pop);
			fill_q   <= fill_q + 3'(push_count) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			entry_q[wr_ptr_q] <= push_tok0;
		end
		if (push_count == 2'd2) begin
			entry_q[wr_ptr_q + 2'd1] <= push_tok1;
		end
	end

endmodule

[rtl/expression_lexer.sv]
// ----------------------------------------------------------------------------
// expression_lexer: arithmetic expression tokenizer
// Turns a stream of source bytes into operator, parenthesis and number
// tokens, one byte per cycle while the token queue has room.
// ----------------------------------------------------------------------------
//
//   channel  | direction | beat type   | handshake
//   ---------+-----------+-------------+------------------------
//   char     | in        | char_beat_t | char_valid / char_ready
//   tok      | out       | token_t     | tok_valid / tok_ready
//
// A byte is registered on acceptance and handled, once the queue has room, by
// one pass of the lexer logic, which writes zero, one or two tokens into a
// four-entry token queue; the first token can leave in the cycle after that.
// One byte is taken every cycle while the queue keeps room for two tokens.
// The queue drains one token a cycle while tok_ready is high, so a byte
// that yields two tokens can stall the input in a sustained stream.
// Reset returns the lexer to default mode with an empty queue and a zero
// accumulator. A stall on tok_ready fills the queue and then holds off
// further bytes; nothing is dropped.
module expression_lexer #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_ready,
	input  exl_pkg::char_beat_t char_beat,
	output logic                tok_valid,
	input  logic                tok_ready,
	output exl_pkg::token_t     tok_beat
);
	import exl_pkg::*;

	// Input register stage.
	char_beat_t beat_s1;
	logic       valid_s1;

	// Lexer state: mode, pending operator and the decimal accumulator.
	lex_state_t              st_q;
	logic [NUMBER_WIDTH-1:0] acc_q;

	lex_state_t              st_nxt;
	logic [NUMBER_WIDTH-1:0] acc_nxt;
	token_t                  tok0;
	token_t                  tok1;
	logic [1:0]              tok_count;
	logic [1:0]              push_count;
	logic                    room;
	logic [2:0]              fill;
	logic                    fire;
	logic                    char_accept;

	// The registered byte is consumed once the queue can hold both of the
	// tokens it might produce.
	assign fire        = valid_s1 && room;
	assign char_ready  = !valid_s1 || fire;
	assign char_accept = char_valid && char_ready;
	assign push_count  = fire ? tok_count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '{mode: MODE_DEFAULT, default: '0};
			acc_q    <= '0;
		end else begin
			if (char_ready) begin
				valid_s1 <= char_valid;
			end
			if (fire) begin
				st_q  <= st_nxt;
				acc_q <= acc_nxt;
			end
		end
	end

	// Byte payload needs no reset; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (char_accept) begin
			beat_s1 <= char_beat;
		end
	end

	exl_step #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_step (
		.beat      (beat_s1),
		.st        (st_q),
		.acc       (acc_q),
		.st_nxt    (st_nxt),
		.acc_nxt   (acc_nxt),
		.tok0      (tok0),
		.tok1      (tok1),
		.tok_count (tok_count)
	);

	exl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_tok0  (tok0),
		.push_tok1  (tok1),
		.push_count (push_count),
		.room       (room),
		.fill       (fill),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok_beat   (tok_beat)
	);

	// The queue never holds more than its four entries.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= 3'd4)
		else $error("token queue overfilled");

	// An accepted byte is waiting in the input stage on the next cycle.
	a_byte_held: assert property (@(posedge clk) disable iff (!arst_n)
		char_accept |=> valid_s1)
		else $error("accepted byte lost from input stage");

	// Handling the final byte always leaves the lexer in default mode.
	a_final_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && beat_s1.final_char) |=> (st_q.mode == MODE_DEFAULT))
		else $error("pending token not flushed on final byte");

	// A token taken with nothing pushed shrinks the queue by exactly one.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && tok_ready && (push_count == 2'd0)) |=> (fill == $past(fill) - 3'd1))
		else $error("token queue count out of step");

endmodule
